// File: hw/rtl/sorted_multimap_list_engine_assert.svh
// Assertion macros for the sorted multimap list engine
`ifndef SORTED_MULTIMAP_LIST_ENGINE_ASSERT_SVH
`define SORTED_MULTIMAP_LIST_ENGINE_ASSERT_SVH
// implication checked every clock, off during reset
`define SMLE_ASSERT_IMP(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define SMLE_ASSERT_NXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/smle_pkg.sv
// ----------------------------------------------------------------------------
// smle_pkg
// Types and constants shared by the sorted multimap list engine.
// ----------------------------------------------------------------------------
package smle_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int MAX_RUN      = 16;

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_REM_KEY = 2'd2;
    localparam logic [1:0] ACT_SEARCH  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } smle_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic               value_valid;
        logic               last;
        logic [4:0]         entry_count;
    } smle_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input, reset walk
        logic rewind;    // reset walk to list head
        logic step;      // advance walk: prev <= cur, cur <= link[cur]
        logic skip;      // advance cur only (after unlink)
        logic alloc;     // pop free head, write key/value
        logic link_new;  // splice new slot before cur
        logic unlink;    // unlink cur
        logic capture;   // hold value of cur for emit
    } smle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cur_ok;
        logic free_ok;
        logic rel_ok;
        logic key_eq;
        logic val_eq;
        logic steps_done;
    } smle_sts_t;

endpackage

// File: hw/rtl/smle_datapath.sv
// ----------------------------------------------------------------------------
// smle_datapath
// Slot stores, list and free heads, walk pointers and compare logic.
// ----------------------------------------------------------------------------
module smle_datapath
    import smle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       order_mode,
    input  smle_in_t   in_item,
    input  smle_cmd_t  cmd,
    output smle_sts_t  sts,
    output logic [31:0] cap_value,
    output logic [4:0]  count
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [SW-1:0] NIL = SW'(CAPACITY);

    logic [31:0]   key_mem [CAPACITY];
    logic [31:0]   val_mem [CAPACITY];
    logic [SW-1:0] link_reg [CAPACITY];

    logic [SW-1:0] head_reg, free_reg, prev_reg, cur_reg, steps_reg, new_reg;
    logic [6:0]    pcount_reg;
    smle_in_t      item_reg;
    logic [31:0]   cap_reg;

    logic cur_ok, prev_ok, free_ok;
    logic [IW-1:0] cur_i, prev_i, free_i, new_i;
    logic [31:0] ck, cv;
    logic [SW-1:0] cl;

    assign cur_ok  = cur_reg < NIL;
    assign prev_ok = prev_reg < NIL;
    assign free_ok = free_reg < NIL;
    assign cur_i   = cur_reg[IW-1:0];
    assign prev_i  = prev_reg[IW-1:0];
    assign free_i  = free_reg[IW-1:0];
    assign new_i   = new_reg[IW-1:0];
    assign ck = key_mem[cur_i];
    assign cv = val_mem[cur_i];
    assign cl = link_reg[cur_i];

    logic [31:0] ua, ub;
    assign ua = ck ^ 32'h8000_0000;
    assign ub = item_reg.key ^ 32'h8000_0000;

    assign sts.cur_ok     = cur_ok;
    assign sts.free_ok    = free_ok;
    assign sts.rel_ok     = order_mode ? (ua >= ub) : (ua <= ub);
    assign sts.key_eq     = ck == item_reg.key;
    assign sts.val_eq     = cv == item_reg.value;
    assign sts.steps_done = steps_reg >= NIL;

    assign cap_value = cap_reg;
    assign count     = pcount_reg[4:0];

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            key_mem[free_i] <= item_reg.key;
            val_mem[free_i] <= item_reg.value;
        end
        if (cmd.capture)
            cap_reg <= cv;
        if (cmd.load)
            item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                link_reg[i] <= SW'(i + 1);
            head_reg   <= NIL;
            free_reg   <= '0;
            prev_reg   <= NIL;
            cur_reg    <= NIL;
            steps_reg  <= '0;
            new_reg    <= NIL;
            pcount_reg <= '0;
        end
        else
        begin
            if (cmd.load || cmd.rewind)
            begin
                prev_reg  <= NIL;
                cur_reg   <= head_reg;
                steps_reg <= '0;
            end
            if (cmd.step)
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= cl;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.skip)
            begin
                cur_reg   <= cl;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.alloc)
            begin
                free_reg <= link_reg[free_i];
                new_reg  <= free_reg;
            end
            if (cmd.link_new)
            begin
                link_reg[new_i] <= cur_ok ? cur_reg : NIL;
                if (prev_ok)
                    link_reg[prev_i] <= new_reg;
                else
                    head_reg <= new_reg;
                pcount_reg <= pcount_reg + 1'b1;
            end
            if (cmd.unlink)
            begin
                if (prev_ok)
                    link_reg[prev_i] <= cl;
                else
                    head_reg <= cl;
                link_reg[cur_i] <= free_reg;
                free_reg <= cur_reg;
                if (pcount_reg != '0)
                    pcount_reg <= pcount_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/smle_controller.sv
// ----------------------------------------------------------------------------
// smle_controller
// Sequences one operation: walk, splice or unlink, emit result transfers.
// ----------------------------------------------------------------------------
module smle_controller
    import smle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  smle_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output smle_out_t  out_data,
    output smle_cmd_t  cmd,
    input  smle_sts_t  sts,
    input  logic [31:0] cap_value,
    input  logic [4:0]  count
);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD_ALLOC, S_ADD_WALK, S_COUNT, S_WALK, S_EMIT, S_DONE
    } state_t;

    state_t      state_reg;
    logic [1:0]  act_reg;
    logic [4:0]  nfound_reg;
    logic        emit_last_reg;
    logic        nfound_max;
    logic        found_reg;
    logic [4:0]  mcount_reg;
    logic [4:0]  rkcnt_reg;
    logic [4:0]  run_cnt;

    assign in_ready   = (state_reg == S_IDLE);
    assign nfound_max = nfound_reg >= 5'(MAX_RUN);
    // remove-key reports the count left after the whole run
    assign run_cnt    = (act_reg == ACT_REM_KEY) ? rkcnt_reg : count;

    // combinational commands
    always_comb
    begin
        cmd = '0;
        cmd.load = in_valid && in_ready;
        case (state_reg)
            S_ADD_ALLOC:
                cmd.alloc = sts.free_ok;
            S_ADD_WALK:
            begin
                if (sts.cur_ok && !sts.steps_done && sts.rel_ok)
                    cmd.step = 1'b1;
                else
                    cmd.link_new = 1'b1;
            end
            S_COUNT:
            begin
                if (sts.cur_ok && !sts.steps_done)
                    cmd.step = 1'b1;
                else
                    cmd.rewind = 1'b1;
            end
            S_WALK:
            begin
                if (sts.cur_ok && !sts.steps_done && !out_valid)
                begin
                    if (act_reg == ACT_REMOVE)
                    begin
                        if (sts.key_eq && sts.val_eq)
                            cmd.unlink = 1'b1;
                        else
                            cmd.step = 1'b1;
                    end
                    else if (sts.key_eq)
                    begin
                        cmd.capture = !nfound_max;
                        if (act_reg == ACT_REM_KEY)
                        begin
                            cmd.unlink = 1'b1;
                            cmd.skip   = 1'b1;
                        end
                        else
                            cmd.step = 1'b1;
                    end
                    else
                        cmd.step = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // A match found during search/remove-key is held in cap_value and
    // emitted as a non-last result when the next match is found; the final one
    // is held back until the walk ends so its last flag is known.
    logic have_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_ADD;
            nfound_reg    <= '0;
            mcount_reg    <= '0;
            rkcnt_reg     <= '0;
            out_valid     <= 1'b0;
            out_data      <= '0;
            emit_last_reg <= 1'b0;
            have_pend_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg       <= in_data.action;
                        nfound_reg    <= '0;
                        mcount_reg    <= '0;
                        have_pend_reg <= 1'b0;
                        if (in_data.action == ACT_ADD)
                            state_reg <= S_ADD_ALLOC;
                        else if (in_data.action == ACT_REM_KEY)
                            state_reg <= S_COUNT;
                        else
                            state_reg <= S_WALK;
                    end
                end
                S_ADD_ALLOC:
                begin
                    if (sts.free_ok)
                        state_reg <= S_ADD_WALK;
                    else
                    begin
                        out_data  <= '{ST_FULL, 32'sd0, 1'b0, 1'b1, count};
                        state_reg <= S_DONE;
                        out_valid <= 1'b1;
                    end
                end
                S_ADD_WALK:
                begin
                    if (cmd.link_new)
                        state_reg <= S_EMIT;
                end
                S_COUNT:
                begin
                    if (sts.cur_ok && !sts.steps_done)
                    begin
                        if (sts.key_eq)
                            mcount_reg <= mcount_reg + 1'b1;
                    end
                    else
                    begin
                        rkcnt_reg <= count - mcount_reg;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (!out_valid || out_ready)
                    begin
                        if (!out_valid && sts.cur_ok && !sts.steps_done)
                        begin
                            if (act_reg == ACT_REMOVE)
                            begin
                                if (cmd.unlink)
                                    state_reg <= S_EMIT;
                            end
                            else if (sts.key_eq && !nfound_max)
                            begin
                                if (have_pend_reg)
                                begin
                                    out_data  <= '{ST_OK, cap_value, 1'b1,
                                                   1'b0, run_cnt};
                                    out_valid <= 1'b1;
                                end
                                have_pend_reg <= 1'b1;
                                nfound_reg    <= nfound_reg + 1'b1;
                            end
                        end
                        else if (!sts.cur_ok || sts.steps_done)
                            state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_DONE;
                        case (act_reg)
                            ACT_ADD:
                                out_data <= '{ST_OK, 32'sd0, 1'b0, 1'b1, count};
                            ACT_REMOVE:
                                out_data <= '{found_reg ? ST_OK : ST_NOMATCH,
                                              32'sd0, 1'b0, 1'b1, count};
                            default:
                            begin
                                if (have_pend_reg)
                                    out_data <= '{ST_OK, cap_value, 1'b1,
                                                  1'b1, run_cnt};
                                else
                                    out_data <= '{ST_NOMATCH, 32'sd0, 1'b0,
                                                  1'b1, run_cnt};
                            end
                        endcase
                    end
                end
                S_DONE:
                begin
                    if (out_valid && out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // remove reaches EMIT from the walk either by unlink (found) or by end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.load)
            found_reg <= 1'b0;
        else if (state_reg == S_WALK && cmd.unlink)
            found_reg <= 1'b1;
    end

endmodule

// File: hw/rtl/sorted_multimap_list_engine.sv
// Remove-key makes two walks: a counting pass, then the unlink pass; each
// walk is at most CAPACITY steps. Each result before the last holds the walk
// until it is accepted. One operation at a time: the next input is taken
// only after the last result has been accepted.
// Reset (rst_n, async): list empty, free chain 0..CAPACITY-1, order_mode 0.
// ----------------------------------------------------------------------------
// sorted_multimap_list_engine
// Ordered key/value list with free chain; add, remove, remove-key, search.
// ----------------------------------------------------------------------------
`include "sorted_multimap_list_engine_assert.svh"

module sorted_multimap_list_engine
    import smle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  smle_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output smle_out_t out_data
);

    logic        order_mode_reg;
    smle_cmd_t   cmd;
    smle_sts_t   sts;
    logic [31:0] cap_value;
    logic [4:0]  count;

    assign cfg_ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            order_mode_reg <= cfg_data;
    end

    smle_controller u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .out_valid, .out_ready, .out_data, .cmd, .sts, .cap_value, .count
    );

    smle_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk, .rst_n, .order_mode(order_mode_reg), .in_item(in_data),
        .cmd, .sts, .cap_value, .count
    );

    `SMLE_ASSERT_IMP(a_no_link_and_unlink, clk, rst_n, cmd.link_new, !cmd.unlink)
    `SMLE_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count <= 5'(CAPACITY))
    `SMLE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
